FILE: rtl/pcf_pkg.sv
// Shared types and constants for the PNG chunk framer.
// Holds the byte phase codes, CRC operation codes, the emit record and the
// byte-wise CRC-32 update. No dependencies.
`timescale 1ns / 1ps

package pcf_pkg;

   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

   // Position of the next byte to emit within one request
   typedef enum logic [3:0] {
      PH_LEN0,
      PH_LEN1,
      PH_LEN2,
      PH_LEN3,
      PH_TYPE0,
      PH_TYPE1,
      PH_TYPE2,
      PH_TYPE3,
      PH_DATA,
      PH_CRC0,
      PH_CRC1,
      PH_CRC2,
      PH_CRC3,
      PH_NONE
   } phase_type;

   typedef enum logic [1:0] {
      CRC_HOLD,
      CRC_FIRST,
      CRC_NEXT,
      CRC_CLEAR
   } crc_op_type;

   typedef struct packed {
      logic       load;
      logic [7:0] out_byte;
      logic       run_last;
      logic       chunk_done;
   } emit_type;

   // Reflected CRC-32, one byte
   function automatic logic [31:0] crc_update_byte(input logic [31:0] crc,
                                                   input logic [7:0]  data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

endpackage

FILE: rtl/pcf_crc.sv
// CRC-32 accumulator for the PNG chunk framer.
// Updates one byte per cycle as bytes are loaded for output; uses pcf_pkg.
`timescale 1ns / 1ps

module pcf_crc (
   input  logic                clock,
   input  logic                reset,
   input  pcf_pkg::crc_op_type crc_op,
   input  logic [7:0]          crc_byte,
   output logic [31:0]         crc_value
);
   import pcf_pkg::*;

   logic [31:0] crc_ff;
   logic [31:0] crc_in;

   always_comb begin
      unique case (crc_op)
         CRC_HOLD:  crc_in = crc_ff;
         CRC_FIRST: crc_in = crc_update_byte(CRC_INIT, crc_byte);
         CRC_NEXT:  crc_in = crc_update_byte(crc_ff, crc_byte);
         CRC_CLEAR: crc_in = CRC_INIT;
         default:   crc_in = crc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc_value = crc_ff;

endmodule

FILE: rtl/pcf_seq.sv
// Request register and byte sequencer for the PNG chunk framer.
// Walks one request through its length, type, data and CRC bytes; uses pcf_pkg.
`timescale 1ns / 1ps

module pcf_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_chunk_start,
   input  logic                req_chunk_end,
   input  logic                req_has_byte,
   input  logic [31:0]         req_chunk_type,
   input  logic [30:0]         req_data_length,
   input  logic [7:0]          req_data_byte,
   input  logic                out_ready,
   input  logic [31:0]         crc_value,
   output pcf_pkg::emit_type   emit,
   output pcf_pkg::crc_op_type crc_op
);
   import pcf_pkg::*;

   logic        item_valid_ff, item_valid_in;
   phase_type   phase_ff, phase_in;
   logic        end_ff;
   logic        has_ff;
   logic [31:0] type_ff;
   logic [30:0] length_ff;
   logic [7:0]  byte_ff;

   phase_type   first_phase;
   phase_type   phase_next;
   logic        load;
   logic        item_done;
   logic        accept;
   logic [31:0] crc_out;

   always_comb begin
      priority if (req_chunk_start) first_phase = PH_LEN0;
      else if (req_has_byte)        first_phase = PH_DATA;
      else if (req_chunk_end)       first_phase = PH_CRC0;
      else                          first_phase = PH_NONE;
   end

   // Next state
   always_comb begin
      unique case (phase_ff)
         PH_LEN0:  phase_next = PH_LEN1;
         PH_LEN1:  phase_next = PH_LEN2;
         PH_LEN2:  phase_next = PH_LEN3;
         PH_LEN3:  phase_next = PH_TYPE0;
         PH_TYPE0: phase_next = PH_TYPE1;
         PH_TYPE1: phase_next = PH_TYPE2;
         PH_TYPE2: phase_next = PH_TYPE3;
         PH_TYPE3: phase_next = has_ff ? PH_DATA : (end_ff ? PH_CRC0 : PH_NONE);
         PH_DATA:  phase_next = end_ff ? PH_CRC0 : PH_NONE;
         PH_CRC0:  phase_next = PH_CRC1;
         PH_CRC1:  phase_next = PH_CRC2;
         PH_CRC2:  phase_next = PH_CRC3;
         default:  phase_next = PH_NONE;
      endcase
   end

   assign load      = item_valid_ff && (phase_ff != PH_NONE) && out_ready;
   assign item_done = item_valid_ff &&
                      ((phase_ff == PH_NONE) || (load && (phase_next == PH_NONE)));
   assign req_stall = item_valid_ff && !item_done;
   assign accept    = req_valid && !req_stall;

   assign item_valid_in = accept ? 1'b1 : (item_done ? 1'b0 : item_valid_ff);
   assign phase_in      = accept ? first_phase : (load ? phase_next : phase_ff);

   // Outputs
   assign crc_out = ~crc_value;

   always_comb begin
      emit.load       = load;
      emit.run_last   = (phase_next == PH_NONE);
      emit.chunk_done = (phase_ff == PH_CRC3);
      unique case (phase_ff)
         PH_LEN0:  emit.out_byte = {1'b0, length_ff[30:24]};
         PH_LEN1:  emit.out_byte = length_ff[23:16];
         PH_LEN2:  emit.out_byte = length_ff[15:8];
         PH_LEN3:  emit.out_byte = length_ff[7:0];
         PH_TYPE0: emit.out_byte = type_ff[31:24];
         PH_TYPE1: emit.out_byte = type_ff[23:16];
         PH_TYPE2: emit.out_byte = type_ff[15:8];
         PH_TYPE3: emit.out_byte = type_ff[7:0];
         PH_DATA:  emit.out_byte = byte_ff;
         PH_CRC0:  emit.out_byte = crc_out[31:24];
         PH_CRC1:  emit.out_byte = crc_out[23:16];
         PH_CRC2:  emit.out_byte = crc_out[15:8];
         PH_CRC3:  emit.out_byte = crc_out[7:0];
         default:  emit.out_byte = 8'd0;
      endcase
   end

   always_comb begin
      if (!load) begin
         crc_op = CRC_HOLD;
      end else begin
         unique case (phase_ff)
            PH_TYPE0: crc_op = CRC_FIRST;
            PH_TYPE1, PH_TYPE2, PH_TYPE3, PH_DATA: crc_op = CRC_NEXT;
            PH_CRC3:  crc_op = CRC_CLEAR;
            default:  crc_op = CRC_HOLD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         phase_ff      <= PH_NONE;
      end else begin
         item_valid_ff <= item_valid_in;
         phase_ff      <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         end_ff    <= req_chunk_end;
         has_ff    <= req_has_byte;
         type_ff   <= req_chunk_type;
         length_ff <= req_data_length;
         byte_ff   <= req_data_byte;
      end
   end

endmodule

FILE: rtl/pcf_out.sv
// Result register for the PNG chunk framer.
// Holds one output byte until the receiver takes it; uses pcf_pkg.
`timescale 1ns / 1ps

module pcf_out (
   input  logic              clock,
   input  logic              reset,
   input  pcf_pkg::emit_type emit,
   output logic              out_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_run_last,
   output logic              rsp_chunk_done
);
   import pcf_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       done_ff;

   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = out_ready ? emit.load : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && emit.load) begin
         byte_ff <= emit.out_byte;
         last_ff <= emit.run_last;
         done_ff <= emit.chunk_done;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_run_last   = last_ff;
   assign rsp_chunk_done = done_ff;

endmodule

FILE: rtl/png_chunk_framer.sv
// PNG chunk framer: turns chunk requests into a framed byte stream with CRC-32.
// Top level; instantiates pcf_seq, pcf_crc and pcf_out, uses pcf_pkg.
//
// Usage:
//   Request channel (req_*): a request with chunk_start brings the chunk type
//   and data length; the block emits the length (big-endian), then the type.
//   A request with has_byte emits its data byte. A request with chunk_end
//   emits the CRC-32 over type and data, big-endian, with rsp_chunk_done on
//   its last byte. A request carries any mix of the three, in that order.
//   Result channel (rsp_*): one byte per transfer; rsp_run_last marks the
//   last byte caused by a request. A request with no flag emits nothing.
//   Output path: the first byte of a request passes through the request register
//   and then the output register before it is valid on rsp_*.
//   Throughput: one output byte per cycle while rsp_stall is low, set by the
//   single output register; a request emits one byte (a plain data byte) up
//   to 13, and data-only requests flow at one per cycle while rsp_stall is low.
//   Reset: synchronous; clears pending requests and results and sets the CRC
//   accumulator to all ones. A receiver stall holds the output byte and
//   backs up into req_stall once the request register cannot drain.
`timescale 1ns / 1ps

module png_chunk_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_chunk_start,
   input  logic        req_chunk_end,
   input  logic        req_has_byte,
   input  logic [31:0] req_chunk_type,
   input  logic [30:0] req_data_length,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_chunk_done
);
   import pcf_pkg::*;

   emit_type    emit;
   crc_op_type  crc_op;
   logic [31:0] crc_value;
   logic        out_ready;

   pcf_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_chunk_start (req_chunk_start),
      .req_chunk_end   (req_chunk_end),
      .req_has_byte    (req_has_byte),
      .req_chunk_type  (req_chunk_type),
      .req_data_length (req_data_length),
      .req_data_byte   (req_data_byte),
      .out_ready       (out_ready),
      .crc_value       (crc_value),
      .emit            (emit),
      .crc_op          (crc_op)
   );

   pcf_crc u_crc (
      .clock     (clock),
      .reset     (reset),
      .crc_op    (crc_op),
      .crc_byte  (emit.out_byte),
      .crc_value (crc_value)
   );

   pcf_out u_out (
      .clock          (clock),
      .reset          (reset),
      .emit           (emit),
      .out_ready      (out_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_chunk_done (rsp_chunk_done)
   );

endmodule

FILE: rtl/pcf_checker.sv
// Port-level checks for the PNG chunk framer, bound to png_chunk_framer.
// Sees the top-level ports only; no package dependency.
`timescale 1ns / 1ps

module pcf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_chunk_done
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_byte) && $stable(rsp_run_last)
                                 && $stable(rsp_chunk_done))
      else $error("stalled result changed");

   // The closing CRC byte always ends the request that caused it
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_chunk_done |-> rsp_run_last)
      else $error("chunk_done without run_last");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind png_chunk_framer pcf_checker u_pcf_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_run_last   (rsp_run_last),
   .rsp_chunk_done (rsp_chunk_done)
);

FILE: dv/pcf_frame_checker.sv
// Scoreboard for the PNG chunk framer: predicts the framed byte stream and CRC-32
// from the accepted requests and compares every accepted result byte.
// Depends on pcf_pkg for the CRC constants.
`timescale 1ns / 1ps

module pcf_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_chunk_start,
   input  logic        req_chunk_end,
   input  logic        req_has_byte,
   input  logic [31:0] req_chunk_type,
   input  logic [30:0] req_data_length,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_run_last,
   input  logic        rsp_chunk_done,
   output int          mismatch_count,
   output int          bytes_pending
);
   import pcf_pkg::*;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       chunk_done;
   } framed_byte_type;

   framed_byte_type framed_bytes_due[$];
   logic [31:0]     crc_running;

   initial begin
      mismatch_count = 0;
      bytes_pending  = 0;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Bit-serial form of the reflected CRC-32 update
   function automatic logic [31:0] crc32_fold(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      logic        feedback;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         feedback = c[0] ^ b[i];
         c = c >> 1;
         if (feedback) c = c ^ CRC_POLY;
      end
      return c;
   endfunction

   function automatic framed_byte_type framed(input logic [7:0] b, input logic done);
      framed_byte_type fb;
      fb.out_byte   = b;
      fb.run_last   = 1'b0;
      fb.chunk_done = done;
      return fb;
   endfunction

   task automatic predict_framing();
      framed_byte_type run[$];
      logic [31:0]     length_word;
      logic [31:0]     crc_word;
      length_word = {1'b0, req_data_length};
      if (req_chunk_start) begin
         for (int s = 3; s >= 0; s--) run.push_back(framed(length_word[8*s +: 8], 1'b0));
         for (int s = 3; s >= 0; s--) run.push_back(framed(req_chunk_type[8*s +: 8], 1'b0));
         // a start always restarts the CRC, abandoning any open chunk
         crc_running = CRC_INIT;
         for (int s = 3; s >= 0; s--) crc_running = crc32_fold(crc_running, req_chunk_type[8*s +: 8]);
      end
      if (req_has_byte) begin
         run.push_back(framed(req_data_byte, 1'b0));
         crc_running = crc32_fold(crc_running, req_data_byte);
      end
      if (req_chunk_end) begin
         crc_word = ~crc_running;
         for (int s = 3; s >= 0; s--) run.push_back(framed(crc_word[8*s +: 8], s == 0));
         crc_running = CRC_INIT;
      end
      if (run.size() > 0) run[run.size() - 1].run_last = 1'b1;
      foreach (run[i]) framed_bytes_due.push_back(run[i]);
   endtask

   always @(posedge clock) begin
      framed_byte_type want;
      framed_byte_type got;
      if (reset) begin
         framed_bytes_due.delete();
         crc_running = CRC_INIT;
      end else begin
         if (req_valid && !req_stall) predict_framing();
         if (rsp_valid && !rsp_stall) begin
            got.out_byte   = rsp_out_byte;
            got.run_last   = rsp_run_last;
            got.chunk_done = rsp_chunk_done;
            if (framed_bytes_due.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h run_last %b chunk_done %b",
                                         got.out_byte, got.run_last, got.chunk_done));
            end else begin
               want = framed_bytes_due.pop_front();
               if (got !== want)
                  report_mismatch($sformatf(
                     "byte %02h/%02h run_last %b/%b chunk_done %b/%b (got/expected)",
                     got.out_byte, want.out_byte, got.run_last, want.run_last,
                     got.chunk_done, want.chunk_done));
            end
         end
      end
      bytes_pending <= framed_bytes_due.size();
   end

endmodule

FILE: dv/testbench.sv
// Top of the PNG chunk framer regression: clock, reset, request stimulus,
// result-side stalls, watchdog and verdict. Depends on png_chunk_framer,
// pcf_frame_checker and pcf_pkg.
`timescale 1ns / 1ps

module testbench;

   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_ITEMS  = 140;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_chunk_start;
   logic        req_chunk_end;
   logic        req_has_byte;
   logic [31:0] req_chunk_type;
   logic [30:0] req_data_length;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_chunk_done;

   int mismatch_count;
   int bytes_pending;
   int send_idle_pct;
   int recv_idle_pct;
   int requests_sent;
   int quiet_cycles;

   png_chunk_framer dut (.*);

   pcf_frame_checker framer_checker (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("png_chunk_framer regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input logic start, input logic fin, input logic has,
                               input logic [31:0] ctype, input logic [30:0] len,
                               input logic [7:0] dbyte);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_chunk_start <= start;
      req_chunk_end   <= fin;
      req_has_byte    <= has;
      req_chunk_type  <= ctype;
      req_data_length <= len;
      req_data_byte   <= dbyte;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // requests with no flag set are ignored by the block
      if (start || fin || has) requests_sent++;
   endtask

   task automatic send_noise();
      send_request(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                   $urandom, 31'($urandom), 8'($urandom));
   endtask

   // One chunk of nbytes data bytes, spread over a run of requests; its length field is sometimes random
   task automatic send_chunk(input int nbytes);
      logic [31:0] ctype;
      logic [30:0] len;
      logic        with_byte;
      int          left;
      ctype = $urandom;
      len   = ($urandom_range(7) == 0) ? 31'($urandom) : 31'(nbytes);
      left  = nbytes;
      if (left <= 1 && $urandom_range(2) == 0) begin
         send_request(1'b1, 1'b1, left == 1, ctype, len, 8'($urandom));
      end else begin
         with_byte = (left > 0) && ($urandom_range(1) == 1);
         send_request(1'b1, 1'b0, with_byte, ctype, len, 8'($urandom));
         if (with_byte) left--;
         while (left > 1 || (left == 1 && $urandom_range(1) == 1)) begin
            if ($urandom_range(15) == 0)
               send_request(1'b0, 1'b0, 1'b0, $urandom, 31'($urandom), 8'($urandom));
            send_request(1'b0, 1'b0, 1'b1, $urandom, 31'($urandom), 8'($urandom));
            left--;
         end
         send_request(1'b0, 1'b1, left == 1, $urandom, 31'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      int target;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_chunk_start <= 1'b0;
      req_chunk_end   <= 1'b0;
      req_has_byte    <= 1'b0;
      req_chunk_type  <= '0;
      req_data_length <= '0;
      req_data_byte   <= '0;
      rsp_stall       <= 1'b0;
      quiet_cycles    <= 0;
      send_idle_pct = 33;
      recv_idle_pct = 48;
      requests_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // data and end with no chunk open: CRC runs on from all ones
      send_request(1'b0, 1'b0, 1'b1, 32'h0, 31'h0, 8'hA5);
      send_request(1'b0, 1'b1, 1'b0, 32'h0, 31'h0, 8'h00);
      send_request(1'b0, 1'b1, 1'b0, 32'h0, 31'h0, 8'h00);
      // no flag: nothing emitted, state untouched
      send_request(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'hFF);
      // empty IEND chunk
      send_request(1'b1, 1'b1, 1'b0, 32'h4945_4E44, 31'h0, 8'h00);
      // field extremes
      send_request(1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'hFF);
      send_request(1'b0, 1'b0, 1'b1, 32'h0, 31'h0, 8'h00);
      send_request(1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'h80);
      // everything in one request: thirteen bytes
      send_request(1'b1, 1'b1, 1'b1, 32'h0, 31'h0, 8'h00);
      send_request(1'b1, 1'b1, 1'b1, 32'h4944_4154, 31'h1, 8'h5A);
      // restart inside an open chunk, then a length that does not match
      send_request(1'b1, 1'b0, 1'b1, 32'h4944_4154, 31'd5, 8'h12);
      send_request(1'b0, 1'b0, 1'b1, 32'h0, 31'h0, 8'h34);
      send_request(1'b1, 1'b0, 1'b0, 32'h7445_5874, 31'd3, 8'h00);
      send_request(1'b0, 1'b0, 1'b1, 32'h0, 31'h0, 8'h56);
      send_request(1'b0, 1'b1, 1'b0, 32'h0, 31'h0, 8'h00);
      send_request(1'b1, 1'b0, 1'b0, 32'h4944_4154, 31'd100, 8'h00);
      send_request(1'b0, 1'b0, 1'b1, 32'h0, 31'h0, 8'h01);
      send_request(1'b0, 1'b1, 1'b1, 32'h0, 31'h0, 8'hFE);

      target = 0;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 33;
               recv_idle_pct = 48;
            end
            1: begin
               send_idle_pct = 48;
               recv_idle_pct = 33;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         target += PHASE_ITEMS;
         while (requests_sent < target) begin
            if ($urandom_range(99) < 85)
               send_chunk(($urandom_range(19) == 0) ? $urandom_range(40, 64)
                                                    : $urandom_range(0, 12));
            else
               send_noise();
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);

      while (bytes_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && bytes_pending == 0) begin
         $display("png_chunk_framer regression: pass");
      end else begin
         $display("png_chunk_framer regression: fail");
      end
      $finish;
   end

endmodule
